### rtl/esp_pkg.sv
`default_nettype none
package esp_pkg;

   localparam int SLOTS   = 64;
   localparam int AW      = $clog2(SLOTS);
   localparam int IW      = 7;
   localparam logic [IW-1:0] LIST_END = IW'(SLOTS);

   typedef logic [IW-1:0] idx_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_SWEEP  = 2'd1,
      KIND_READ   = 2'd2,
      KIND_INIT   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } stat_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT_WR,
      OP_INS_RD,
      OP_INS_WR,
      OP_RD_RD,
      OP_SW_RD,
      OP_SW_EV,
      OP_SW_FIX,
      OP_RSP
   } op_type;

   // one stored slot, apart from its link
   typedef struct packed {
      logic [15:0]        etype;
      logic [15:0]        volume;
      logic [31:0]        expiry;
      logic               never;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } entry_type;

   localparam int EW = $bits(entry_type);

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic fh_end;
      logic cur_end;
      logic expire;
      logic prev_end;
      logic init_last;
   } sts_type;

endpackage
`default_nettype wire

### rtl/esp_ram.sv
`default_nettype none
module esp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/esp_ctrl.sv
`default_nettype none
module esp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_fire,
   input  wire logic [1:0]       req_kind,
   input  wire logic             rsp_fire,
   input  wire esp_pkg::sts_type sts,
   output esp_pkg::cmd_type      cmd,
   output logic                  req_ready,
   output logic                  rsp_valid
);
   import esp_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_INS, ST_INS_WR, ST_RD,
      ST_SW_RD, ST_SW_EV, ST_SW_FIX, ST_RSP, ST_OUT
   } state_type;

   state_type state_ff;
   logic      init_rsp_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // decode the datapath operation for this cycle
   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         ST_INIT:   cmd.op = OP_INIT_WR;
         ST_IDLE:   cmd.op = req_fire ? OP_LOAD : OP_NONE;
         ST_INS:    cmd.op = sts.fh_end ? OP_NONE : OP_INS_RD;
         ST_INS_WR: cmd.op = OP_INS_WR;
         ST_RD:     cmd.op = OP_RD_RD;
         ST_SW_RD:  cmd.op = sts.cur_end ? OP_NONE : OP_SW_RD;
         ST_SW_EV:  cmd.op = OP_SW_EV;
         ST_SW_FIX: cmd.op = OP_SW_FIX;
         ST_RSP:    cmd.op = OP_RSP;
         default:   cmd.op = OP_NONE;
      endcase
   end

   // sequence each request; reset starts with a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         init_rsp_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_INIT: begin
               if (sts.init_last) begin
                  state_ff <= init_rsp_ff ? ST_RSP : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  case (kind_type'(req_kind))
                     KIND_INSERT: state_ff <= ST_INS;
                     KIND_SWEEP:  state_ff <= ST_SW_RD;
                     KIND_READ:   state_ff <= ST_RD;
                     default: begin
                        state_ff    <= ST_INIT;
                        init_rsp_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_INS:    state_ff <= sts.fh_end ? ST_RSP : ST_INS_WR;
            ST_INS_WR: state_ff <= ST_RSP;
            ST_RD:     state_ff <= ST_RSP;
            ST_SW_RD:  state_ff <= sts.cur_end ? ST_RSP : ST_SW_EV;
            ST_SW_EV: begin
               state_ff <= (sts.expire && !sts.prev_end) ? ST_SW_FIX : ST_SW_RD;
            end
            ST_SW_FIX: state_ff <= ST_SW_RD;
            ST_RSP:    state_ff <= ST_OUT;
            ST_OUT: begin
               if (rsp_fire) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### rtl/esp_dpath.sv
`default_nettype none
module esp_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire esp_pkg::cmd_type  cmd,
   output esp_pkg::sts_type       sts,
   input  wire logic [1:0]        req_kind,
   input  wire logic [150:0]      req_fields,
   input  wire logic              csr_fire,
   input  wire logic [6:0]        csr_value,
   output logic      [143:0]      rsp_data
);
   import esp_pkg::*;

   logic [6:0]         reserved_ff;
   kind_type           kind_ff;
   logic [31:0]        now_ff;
   logic [15:0]        typ_ff, vol_ff;
   logic [31:0]        exp_ff;
   logic signed [15:0] x_ff, y_ff, z_ff;
   idx_type            idx_ff;
   idx_type            ah_ff, fh_ff, cnt_ff, cur_ff, prev_ff, rv_ff, slot_ff;
   logic [AW-1:0]      ic_ff;
   logic               ins_ok_ff;
   logic [143:0]       rsp_ff;

   logic               link_we, data_we;
   logic [AW-1:0]      link_waddr, raddr;
   idx_type            link_wdata, link_rd;
   entry_type          data_wdata, data_rd;

   logic [32:0]        exp_sum;
   idx_type            ic_ext, init_link;
   logic               in_res;
   entry_type          rsp_entry;
   idx_type            rsp_link, rsp_slot;
   stat_type           rsp_stat;
   logic               read_ok;

   assign exp_sum   = {1'b0, req_fields[31:0]} + {1'b0, req_fields[95:64]};
   assign ic_ext    = IW'(ic_ff);
   assign in_res    = ic_ext < rv_ff;
   assign init_link = in_res ? ((ic_ff == '0) ? LIST_END : ic_ext - 1'b1)
                             : ic_ext + 1'b1;

   assign sts.fh_end    = fh_ff >= LIST_END;
   assign sts.cur_end   = cur_ff >= LIST_END;
   assign sts.prev_end  = prev_ff >= LIST_END;
   assign sts.expire    = !data_rd.never && (data_rd.expiry <= now_ff);
   assign sts.init_last = ic_ff == AW'(SLOTS - 1);

   // pick the memory address and write data for the operation
   always_comb begin
      raddr      = cur_ff[AW-1:0];
      link_we    = 1'b0;
      data_we    = 1'b0;
      link_waddr = ic_ff;
      link_wdata = init_link;
      data_wdata = '0;
      case (cmd.op)
         OP_INIT_WR: begin
            link_we          = 1'b1;
            data_we          = 1'b1;
            data_wdata.never = in_res;
         end
         OP_INS_RD: raddr = fh_ff[AW-1:0];
         OP_RD_RD:  raddr = idx_ff[AW-1:0];
         OP_INS_WR: begin
            link_we    = 1'b1;
            data_we    = 1'b1;
            link_waddr = fh_ff[AW-1:0];
            link_wdata = ah_ff;
            data_wdata = '{etype: typ_ff, volume: vol_ff, expiry: exp_ff,
                           never: 1'b0, x: x_ff, y: y_ff, z: z_ff};
         end
         OP_SW_EV: begin
            link_we    = sts.expire;
            link_waddr = cur_ff[AW-1:0];
            link_wdata = fh_ff;
         end
         OP_SW_FIX: begin
            link_we    = 1'b1;
            link_waddr = prev_ff[AW-1:0];
            link_wdata = cur_ff;
         end
         default: ;
      endcase
   end

   esp_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_link_ram (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(raddr), .rdata(link_rd)
   );

   esp_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_data_ram (
      .clock(clock), .we(data_we), .waddr(link_waddr), .wdata(data_wdata),
      .raddr(raddr), .rdata(data_rd)
   );

   // assemble the result fields
   always_comb begin
      read_ok   = (kind_ff == KIND_READ) && (idx_ff < LIST_END);
      rsp_entry = read_ok ? data_rd : '0;
      rsp_link  = read_ok ? link_rd : LIST_END;
      rsp_stat  = STAT_OK;
      rsp_slot  = LIST_END;
      case (kind_ff)
         KIND_INSERT: begin
            rsp_stat = ins_ok_ff ? STAT_OK : STAT_FULL;
            rsp_slot = ins_ok_ff ? slot_ff : LIST_END;
         end
         KIND_READ: begin
            rsp_stat = read_ok ? STAT_OK : STAT_RANGE;
            rsp_slot = read_ok ? idx_ff : LIST_END;
         end
         default: ;
      endcase
   end

   assign rsp_data = rsp_ff;

   // hold request fields and the payload of the result
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         kind_ff <= kind_type'(req_kind);
         now_ff  <= req_fields[31:0];
         typ_ff  <= req_fields[47:32];
         vol_ff  <= req_fields[63:48];
         exp_ff  <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
         x_ff    <= req_fields[111:96];
         y_ff    <= req_fields[127:112];
         z_ff    <= req_fields[143:128];
         idx_ff  <= req_fields[150:144];
      end
      if (cmd.op == OP_INS_WR) begin
         slot_ff <= fh_ff;
      end
      if (cmd.op == OP_RSP) begin
         rsp_ff <= {1'b0, cnt_ff, ah_ff, rsp_link, rsp_entry.z, rsp_entry.y,
                    rsp_entry.x, rsp_entry.never, rsp_entry.expiry,
                    rsp_entry.volume, rsp_entry.etype, rsp_slot, rsp_stat};
      end
   end

   // advance list heads, count and walk pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= 7'd1;
         rv_ff       <= IW'(1);
         ic_ff       <= '0;
         ah_ff       <= '0;
         fh_ff       <= IW'(1);
         cnt_ff      <= IW'(1);
         cur_ff      <= LIST_END;
         prev_ff     <= LIST_END;
         ins_ok_ff   <= 1'b0;
      end else begin
         if (csr_fire) begin
            reserved_ff <= csr_value;
         end
         case (cmd.op)
            OP_LOAD: begin
               rv_ff     <= (reserved_ff > LIST_END) ? LIST_END : reserved_ff;
               ic_ff     <= '0;
               cur_ff    <= ah_ff;
               prev_ff   <= LIST_END;
               ins_ok_ff <= 1'b0;
            end
            OP_INIT_WR: begin
               ic_ff  <= ic_ff + 1'b1;
               ah_ff  <= (rv_ff == '0) ? LIST_END : rv_ff - 1'b1;
               fh_ff  <= rv_ff;
               cnt_ff <= rv_ff;
            end
            OP_INS_WR: begin
               fh_ff     <= link_rd;
               ah_ff     <= fh_ff;
               cnt_ff    <= cnt_ff + 1'b1;
               ins_ok_ff <= 1'b1;
            end
            OP_SW_EV: begin
               cur_ff <= link_rd;
               if (sts.expire) begin
                  fh_ff <= cur_ff;
                  if (cnt_ff != '0) begin
                     cnt_ff <= cnt_ff - 1'b1;
                  end
                  if (sts.prev_end) begin
                     ah_ff <= link_rd;
                  end
               end else begin
                  prev_ff <= cur_ff;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### rtl/expiring_slot_pool.sv
`default_nettype none
// Insert reads the free head, then writes the slot unless the pool is full; read fetches one slot;
// sweep checks each active slot and frees the expired ones; initialize is a 64-entry write pass over both memories.
// One request at a time; the sweep walk through the memories, each with one write port and a
// registered read port, sets its length.
// Reset: synchronous, active high; afterward a clearing pass builds the lists
// with one reserved slot, and no request is taken until it ends.
module expiring_slot_pool (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // now_time, sound_type, volume, duration, origin_x, origin_y, origin_z,
   // slot_index, pad
   input  wire logic [151:0] req_tdata,
   // kind
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status, slot, entry_type, entry_volume, entry_expiry, entry_never, entry_x,
   // entry_y, entry_z, entry_link, active_first, active_total, pad
   output logic      [143:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [6:0]   csr_wdata
);
   import esp_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_fire, rsp_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;

   esp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_kind(req_tuser),
      .rsp_fire(rsp_fire), .sts(sts), .cmd(cmd), .req_ready(req_tready),
      .rsp_valid(rsp_tvalid)
   );

   esp_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_kind(req_tuser),
      .req_fields(req_tdata[150:0]), .csr_fire(csr_valid && csr_ready),
      .csr_value(csr_wdata), .rsp_data(rsp_tdata)
   );

   // no request is taken while the clearing pass runs
   a_clear_pass: assert property (@(posedge clock) $fell(reset) |-> !req_tready)
      else $error("request taken during clearing pass");
   // one request in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while result pending");
   // active count never exceeds the pool
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[142:136] <= LIST_END)
      else $error("active count beyond pool");
   // a full pool reports no slot
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == STAT_FULL) |-> rsp_tdata[8:2] == LIST_END)
      else $error("full status with slot");
endmodule
`default_nettype wire
